// ----- src/rpe_pkg.sv -----
package rpe_pkg;

   localparam int MAX_EDGES_DEF  = 64;
   localparam int COORD_BITS_DEF = 32;
   localparam int NUDGE_BITS     = 17;
   localparam logic [NUDGE_BITS-1:0] NUDGE_RESET = 17'd65543;

   typedef enum logic {
      ACT_WRITE = 1'b0,
      ACT_QUERY = 1'b1
   } action_type;

   typedef struct packed {
      logic                           action;
      logic [6:0]                     vertex_index;
      logic signed [COORD_BITS_DEF-1:0] vertex_x;
      logic signed [COORD_BITS_DEF-1:0] vertex_y;
      logic signed [COORD_BITS_DEF-1:0] start_x;
      logic signed [COORD_BITS_DEF-1:0] start_y;
      logic signed [COORD_BITS_DEF-1:0] end_x;
      logic signed [COORD_BITS_DEF-1:0] end_y;
      logic [6:0]                     edge_count;
   } req_type;

   typedef struct packed {
      logic                           hit;
      logic [5:0]                     edge_index;
      logic signed [COORD_BITS_DEF-1:0] hit_x;
      logic signed [COORD_BITS_DEF-1:0] hit_y;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;      // capture query, clear edge counter
      logic rd;        // read second corner at edge counter plus one
      logic calc;      // products of current edge
      logic test;      // sign and range test
      logic div_start;
      logic div_step;
      logic mul_a;     // tq times nudge
      logic mul_b;     // |s1| times low half
      logic mul_c;     // plus |s1| times high half
      logic fin;
      logic next;      // advance edge counter
   } cmd_type;

   typedef struct packed {
      logic last;      // edge counter reached count
      logic pass;      // current edge is hit
      logic div_done;
   } sts_type;

endpackage

// ----- src/rpe_ctrl.sv -----
module rpe_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             go,
   input  rpe_pkg::sts_type sts,
   output rpe_pkg::cmd_type cmd,
   output logic             busy,
   output logic             done
);

   typedef enum logic [3:0] {
      S_IDLE, S_CHK, S_RD, S_CALC, S_TEST, S_DIVS, S_DIV, S_MA, S_MB, S_MC, S_FIN,
      S_NONE
   } state_type;

   state_type state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done     <= 1'b0;
      end else begin
         done <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (go) state_ff <= S_CHK;
            S_CHK:  state_ff <= sts.last ? S_NONE : S_RD;
            S_RD:   state_ff <= S_CALC;
            S_CALC: state_ff <= S_TEST;
            S_TEST: state_ff <= sts.pass ? S_DIVS : S_CHK;
            S_DIVS: state_ff <= S_DIV;
            S_DIV:  if (sts.div_done) state_ff <= S_MA;
            S_MA:   state_ff <= S_MB;
            S_MB:   state_ff <= S_MC;
            S_MC:   state_ff <= S_FIN;
            S_FIN: begin
               state_ff <= S_IDLE;
               done     <= 1'b1;
            end
            S_NONE: begin
               state_ff <= S_IDLE;
               done     <= 1'b1;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_comb begin
      cmd           = '0;
      cmd.load      = (state_ff == S_IDLE) && go;
      cmd.rd        = (state_ff == S_RD);
      cmd.calc      = (state_ff == S_CALC);
      cmd.test      = (state_ff == S_TEST);
      cmd.next      = (state_ff == S_TEST) && !sts.pass;
      cmd.div_start = (state_ff == S_DIVS);
      cmd.div_step  = (state_ff == S_DIV);
      cmd.mul_a     = (state_ff == S_MA);
      cmd.mul_b     = (state_ff == S_MB);
      cmd.mul_c     = (state_ff == S_MC);
      cmd.fin       = (state_ff == S_FIN) || (state_ff == S_NONE);
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// ----- src/rpe_dp.sv -----
module rpe_dp (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [6:0]                                wr_idx,
   input  logic signed [rpe_pkg::COORD_BITS_DEF-1:0] wr_x,
   input  logic signed [rpe_pkg::COORD_BITS_DEF-1:0] wr_y,
   input  logic signed [rpe_pkg::COORD_BITS_DEF-1:0] q_sx,
   input  logic signed [rpe_pkg::COORD_BITS_DEF-1:0] q_sy,
   input  logic signed [rpe_pkg::COORD_BITS_DEF-1:0] q_ex,
   input  logic signed [rpe_pkg::COORD_BITS_DEF-1:0] q_ey,
   input  logic [6:0]                                q_cnt,
   input  logic [rpe_pkg::NUDGE_BITS-1:0]            nudge,
   input  rpe_pkg::cmd_type                          cmd,
   output rpe_pkg::sts_type                          sts,
   output logic                                      o_hit,
   output logic [5:0]                                o_edge,
   output logic signed [rpe_pkg::COORD_BITS_DEF-1:0] o_x,
   output logic signed [rpe_pkg::COORD_BITS_DEF-1:0] o_y
);

   localparam int MAX_EDGES  = rpe_pkg::MAX_EDGES_DEF;
   localparam int COORD_BITS = rpe_pkg::COORD_BITS_DEF;
   localparam int DEPTH = MAX_EDGES + 1;
   localparam int AW    = $clog2(DEPTH);
   localparam int EW    = $clog2(MAX_EDGES + 1);
   localparam int CB    = COORD_BITS;
   localparam int DW    = CB + 1;      // differences
   localparam int PW    = 2 * DW + 1;  // cross terms
   localparam int NB    = rpe_pkg::NUDGE_BITS;
   localparam int TW    = 33;          // tq, up to 2^32
   localparam int QW    = TW + NB;     // tq*nudge
   localparam int QL    = QW / 2;      // half of tq*nudge per multiply
   localparam int MW    = DW + QW;
   localparam int TP    = MW - 48;

   logic signed [CB-1:0] mem_x [DEPTH];
   logic signed [CB-1:0] mem_y [DEPTH];
   logic signed [CB-1:0] v0x_ff, v0y_ff, v1x_ff, v1y_ff;

   logic signed [CB-1:0] p0x_ff, p0y_ff;
   logic signed [DW-1:0] s1x_ff, s1y_ff;
   logic [EW-1:0]        cnt_ff, idx_ff;
   logic signed [PW-1:0] den_ff, sn_ff, tn_ff;
   logic [PW-1:0]        rem_ff;
   logic [TW-1:0]        tq_ff;
   logic [5:0]           k_ff;
   logic [QW-1:0]        tqn_ff;
   logic [MW-1:0]        mx_ff, my_ff;
   logic                 hit_pend;

   logic [EW-1:0] cnt_in;
   always_comb begin
      if (q_cnt > 7'(MAX_EDGES)) cnt_in = EW'(MAX_EDGES);
      else                        cnt_in = EW'(q_cnt);
   end

   always_ff @(posedge clock) begin
      if (wr_en && (wr_idx <= 7'(MAX_EDGES))) begin
         mem_x[wr_idx[AW-1:0]] <= wr_x;
         mem_y[wr_idx[AW-1:0]] <= wr_y;
      end
   end

   // two reads per edge, made in different states, so one read port serves both
   always_ff @(posedge clock) begin
      if (cmd.load || cmd.next) begin
         v0x_ff <= mem_x[cmd.load ? AW'(0) : AW'(idx_ff + 1'b1)];
         v0y_ff <= mem_y[cmd.load ? AW'(0) : AW'(idx_ff + 1'b1)];
      end else if (cmd.rd) begin
         v1x_ff <= mem_x[AW'(idx_ff + 1'b1)];
         v1y_ff <= mem_y[AW'(idx_ff + 1'b1)];
      end
   end

   logic signed [DW-1:0] s2x, s2y, dx, dy;
   assign s2x = DW'(v1x_ff) - DW'(v0x_ff);
   assign s2y = DW'(v1y_ff) - DW'(v0y_ff);
   assign dx  = DW'(p0x_ff) - DW'(v0x_ff);
   assign dy  = DW'(p0y_ff) - DW'(v0y_ff);

   logic signed [2*DW-1:0] m_den_a, m_den_b, m_sn_a, m_sn_b, m_tn_a, m_tn_b;
   assign m_den_a = s1x_ff * s2y;
   assign m_den_b = s2x * s1y_ff;
   assign m_sn_a  = s1x_ff * dy;
   assign m_sn_b  = s1y_ff * dx;
   assign m_tn_a  = s2x * dy;
   assign m_tn_b  = s2y * dx;

   logic den_neg;
   logic signed [PW-1:0] dn_a, sn_a, tn_a;
   assign den_neg = den_ff[PW-1];
   assign dn_a = den_neg ? -den_ff : den_ff;
   assign sn_a = den_neg ? -sn_ff : sn_ff;
   assign tn_a = den_neg ? -tn_ff : tn_ff;

   logic pass;
   assign pass = (den_ff != '0) && !sn_a[PW-1] && !tn_a[PW-1]
                 && (sn_a <= dn_a) && (tn_a <= dn_a);

   logic [PW-1:0] rsh, rsub;
   assign rsh  = {rem_ff[PW-2:0], 1'b0};
   assign rsub = rsh - dn_a;

   logic [DW-1:0] ax, ay;
   assign ax = s1x_ff[DW-1] ? DW'(-s1x_ff) : DW'(s1x_ff);
   assign ay = s1y_ff[DW-1] ? DW'(-s1y_ff) : DW'(s1y_ff);

   logic [QW-1:0] tqn_in;
   assign tqn_in = tq_ff * nudge;

   // |s1| times tq*nudge in two halves
   logic [QL-1:0]      tq_part;
   logic [DW+QL-1:0]   pmx, pmy;
   assign tq_part = cmd.mul_b ? tqn_ff[QL-1:0] : tqn_ff[QW-1:QL];
   assign pmx     = ax * tq_part;
   assign pmy     = ay * tq_part;

   function automatic logic signed [CB-1:0] place(
      input logic signed [CB-1:0] p, input logic neg, input logic [MW-1:0] m);
      logic signed [TP+1:0] off, sum;
      logic signed [TP+1:0] top, bot;
      off = $signed({2'b00, m[MW-1:48]});
      if (neg) off = -off;
      sum = (TP+2)'(p) + off;
      top = (TP+2)'({1'b0, {(CB-1){1'b1}}});
      bot = -top - 1'b1;
      if (sum > top)      place = top[CB-1:0];
      else if (sum < bot) place = bot[CB-1:0];
      else                place = sum[CB-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         p0x_ff <= q_sx;
         p0y_ff <= q_sy;
         s1x_ff <= DW'(q_ex) - DW'(q_sx);
         s1y_ff <= DW'(q_ey) - DW'(q_sy);
         cnt_ff <= cnt_in;
         idx_ff <= '0;
      end
      if (cmd.next) idx_ff <= idx_ff + 1'b1;
      if (cmd.calc) begin
         den_ff <= PW'(m_den_a) - PW'(m_den_b);
         sn_ff  <= PW'(m_sn_a)  - PW'(m_sn_b);
         tn_ff  <= PW'(m_tn_a)  - PW'(m_tn_b);
      end
      if (cmd.div_start) begin
         rem_ff <= tn_a;
         tq_ff  <= '0;
         k_ff   <= (tn_a == dn_a) ? 6'd32 : 6'd0;
         den_ff <= dn_a;
         tn_ff  <= tn_a;
      end
      if (cmd.div_step) begin
         if (tn_ff == den_ff) begin
            tq_ff <= TW'(1) << 32;
         end else if (k_ff != 6'd32) begin
            k_ff <= k_ff + 1'b1;
            if (!rsub[PW-1] || rsh >= den_ff) begin
               rem_ff <= rsh - den_ff;
               tq_ff  <= {tq_ff[TW-2:0], 1'b1};
            end else begin
               rem_ff <= rsh;
               tq_ff  <= {tq_ff[TW-2:0], 1'b0};
            end
         end
      end
      if (cmd.mul_a) tqn_ff <= tqn_in;
      if (cmd.mul_b) begin
         mx_ff <= MW'(pmx);
         my_ff <= MW'(pmy);
      end
      if (cmd.mul_c) begin
         mx_ff <= mx_ff + {pmx, {QL{1'b0}}};
         my_ff <= my_ff + {pmy, {QL{1'b0}}};
      end
      if (cmd.fin) begin
         o_hit  <= hit_pend;
         o_edge <= hit_pend ? 6'(idx_ff) : '0;
         o_x    <= hit_pend ? place(p0x_ff, s1x_ff[DW-1], mx_ff) : '0;
         o_y    <= hit_pend ? place(p0y_ff, s1y_ff[DW-1], my_ff) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load)                hit_pend <= 1'b0;
      else if (cmd.test && pass)   hit_pend <= 1'b1;
   end

   assign sts.last     = (idx_ff == cnt_ff);
   assign sts.pass     = pass;
   assign sts.div_done = (k_ff == 6'd32) || (tn_ff == den_ff);

endmodule

// ----- src/ray_polygon_edge_intersect.sv -----
// channel | ports                        | handshake
// req     | req_word                     | start high while busy low
// rsp     | rsp_word                     | rsp_valid for one cycle
// csr     | csr_wr_en, csr_wr_data       | write on enable
// a query walks the edges in order, reading, computing and testing each; with no hit
// it strobes after the last edge; a hit stops the walk, goes through the divider
// (which ends at once when t is one) and the split multiplies, then strobes.
// busy holds off req until the strobe; rsp cannot be stalled.
// reset returns the controller to idle and the nudge register to its default.
module ray_polygon_edge_intersect (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  rpe_pkg::req_type               req_word,
   output logic                           rsp_valid,
   output rpe_pkg::rsp_type               rsp_word,
   input  logic                           csr_wr_en,
   input  logic [rpe_pkg::NUDGE_BITS-1:0] csr_wr_data
);

   logic [rpe_pkg::NUDGE_BITS-1:0] nudge_ff;
   rpe_pkg::cmd_type cmd;
   rpe_pkg::sts_type sts;
   logic go, wr;
   logic o_hit;
   logic [5:0] o_edge;
   logic signed [rpe_pkg::COORD_BITS_DEF-1:0] o_x, o_y;

   always_ff @(posedge clock) begin
      if (reset)          nudge_ff <= rpe_pkg::NUDGE_RESET;
      else if (csr_wr_en) nudge_ff <= csr_wr_data;
   end

   assign go = start && !busy && (req_word.action == rpe_pkg::ACT_QUERY);
   assign wr = start && !busy && (req_word.action == rpe_pkg::ACT_WRITE);

   rpe_ctrl u_ctrl (
      .clock (clock), .reset (reset), .go (go), .sts (sts), .cmd (cmd),
      .busy (busy), .done (rsp_valid)
   );

   rpe_dp u_dp (
      .clock (clock), .wr_en (wr), .wr_idx (req_word.vertex_index),
      .wr_x (req_word.vertex_x), .wr_y (req_word.vertex_y),
      .q_sx (req_word.start_x), .q_sy (req_word.start_y),
      .q_ex (req_word.end_x), .q_ey (req_word.end_y),
      .q_cnt (req_word.edge_count), .nudge (nudge_ff), .cmd (cmd), .sts (sts),
      .o_hit (o_hit), .o_edge (o_edge), .o_x (o_x), .o_y (o_y)
   );

   assign rsp_word.hit        = o_hit;
   assign rsp_word.edge_index = o_edge;
   assign rsp_word.hit_x      = o_x;
   assign rsp_word.hit_y      = o_y;

   a_busy_go: assert property (@(posedge clock) disable iff (reset) go |=> busy)
      else $error("query did not raise busy");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while busy");
   a_no_hit_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.hit |-> rsp_word.edge_index == 6'd0)
      else $error("edge index without hit");

endmodule
